### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with rst as disable.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define PRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset
`define PRT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### sv/prt_pkg.sv
// ---------------------------------------------------------------------------
// prt_pkg
// Types and constants shared by the primitive root tester modules.
// ---------------------------------------------------------------------------
package prt_pkg;

  // Residue, base and modulus width
  localparam int DATA_W      = 10;
  // Depth of the seen-residue bitmap
  localparam int MAX_MODULUS = 1024;
  localparam int SEEN_AW     = $clog2(MAX_MODULUS);
  // Bit index into the multiplier operand
  localparam int BIT_IDX_W   = $clog2(DATA_W);

  // Stream payload widths (rounded up to whole bytes)
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  localparam logic [DATA_W-1:0] MODULUS_RESET = DATA_W'(2);

  // Request into the shared modular multiplier
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;   // multiplicand, below m
    logic [DATA_W-1:0] b;   // multiplier, any value
    logic [DATA_W-1:0] m;   // modulus
  } mul_req_t;

  // Status back from the multiplier
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] result;
  } mul_rsp_t;

  // Test sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MUL_START,
    ST_MUL_WAIT,
    ST_LOOKUP,
    ST_CHECK,
    ST_DONE
  } state_t;

  // True when a residue has a slot in the seen bitmap
  function automatic logic in_map(input logic [DATA_W-1:0] r);
    return 32'(r) < 32'(MAX_MODULUS);
  endfunction

endpackage

### sv/primitive_root_tester_unit.sv
// ---------------------------------------------------------------------------
// primitive_root_tester_unit
// Tests a base as a primitive root of the configured modulus by walking
// base^i mod m and stopping on residue 1, on a repeated residue or after m-2 steps.
// ---------------------------------------------------------------------------
//  channel   | dir | signals                      | content
//  ----------+-----+------------------------------+---------------------------
//  s_axis    | in  | s_tvalid s_tready s_tdata    | base
//  m_axis    | out | m_tvalid m_tready m_tdata    | is_primitive, steps_passed
//  cfg       | in  | cfg_wr_en cfg_wr_data        | modulus
//
// Modulus m of 3 or more: accept, bitmap clear, then per power step start,
//   the 10 multiply bits, done, lookup and check, then the result load; at
//   most m-2 power steps, the step time being set by the bit-serial modular
//   multiplier.
// Modulus below 3: accept, then the result load; no bitmap clear, no power steps.
// Bitmap entries 0 to m-1 are cleared at the start of every test with m of 3 or more.
// s_tready is high only while idle; a finished result waits in the output
// register, and the next test starts while it is still pending.
// rst is synchronous, active high.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module primitive_root_tester_unit (
  input  logic                             clk,
  input  logic                             rst,
  // stream in: [9:0] base
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [prt_pkg::IN_TDATA_W-1:0]   s_tdata,
  // stream out: [0] is_primitive, [10:1] steps_passed
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [prt_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // modulus register write
  input  logic                             cfg_wr_en,
  input  logic [prt_pkg::DATA_W-1:0]       cfg_wr_data
);

  localparam int DW = prt_pkg::DATA_W;
  localparam int AW = prt_pkg::SEEN_AW;

  prt_pkg::state_t   state;
  prt_pkg::state_t   state_next;
  prt_pkg::mul_req_t mul_req;
  prt_pkg::mul_rsp_t mul_rsp;

  logic [DW-1:0] modulus;
  logic [DW-1:0] m_reg;
  logic [DW-1:0] base_reg;
  logic [DW-1:0] power;
  logic [DW-1:0] count;
  logic [DW-1:0] clr_cnt;
  logic [DW-1:0] limit;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic          hit;
  logic          stop;
  logic          prim;
  logic          in_check;
  logic          entry_state;

  // Seen bitmap
  logic          seen_mem [prt_pkg::MAX_MODULUS];
  logic          seen_we;
  logic [AW-1:0] seen_waddr;
  logic          seen_wdata;
  logic          seen_rd;

  assign limit    = m_reg - DW'(2);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign hit      = prt_pkg::in_map(power) && seen_rd;
  assign stop     = (power == DW'(1)) || hit || ((count + 1'b1) == limit);
  assign prim     = (m_reg < DW'(3)) || (count >= limit);

  // State decodes for the checks
  assign in_check    = (state == prt_pkg::ST_CHECK);
  assign entry_state = (state == prt_pkg::ST_CLEAR) || (state == prt_pkg::ST_DONE);

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= prt_pkg::MODULUS_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      prt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (modulus < DW'(3)) ? prt_pkg::ST_DONE : prt_pkg::ST_CLEAR;
        end
      end
      prt_pkg::ST_CLEAR: begin
        if (clr_cnt == m_reg - 1'b1) state_next = prt_pkg::ST_MUL_START;
      end
      prt_pkg::ST_MUL_START: state_next = prt_pkg::ST_MUL_WAIT;
      prt_pkg::ST_MUL_WAIT: begin
        if (mul_rsp.done) state_next = prt_pkg::ST_LOOKUP;
      end
      prt_pkg::ST_LOOKUP: state_next = prt_pkg::ST_CHECK;
      prt_pkg::ST_CHECK: begin
        state_next = stop ? prt_pkg::ST_DONE : prt_pkg::ST_MUL_START;
      end
      prt_pkg::ST_DONE: begin
        if (out_free) state_next = prt_pkg::ST_IDLE;
      end
      default: state_next = prt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = power;
    mul_req.b     = base_reg;
    mul_req.m     = m_reg;
    seen_we       = 1'b0;
    seen_waddr    = AW'(power);
    seen_wdata    = 1'b1;
    out_load      = 1'b0;
    case (state)
      prt_pkg::ST_IDLE:      s_tready = 1'b1;
      prt_pkg::ST_CLEAR: begin
        seen_we    = prt_pkg::in_map(clr_cnt);
        seen_waddr = AW'(clr_cnt);
        seen_wdata = 1'b0;
      end
      prt_pkg::ST_MUL_START: mul_req.start = 1'b1;
      prt_pkg::ST_CHECK: begin
        seen_we = !stop && prt_pkg::in_map(power);
      end
      prt_pkg::ST_DONE:      out_load = out_free;
      default: ;
    endcase
  end

  prt_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Test datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      base_reg <= s_tdata[DW-1:0];
      m_reg    <= modulus;
      count    <= '0;
      clr_cnt  <= '0;
      power    <= DW'(1);
    end else begin
      if (state == prt_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (state == prt_pkg::ST_MUL_WAIT && mul_rsp.done) power <= mul_rsp.result;
      if (state == prt_pkg::ST_CHECK && !(power == DW'(1)) && !hit) count <= count + 1'b1;
    end
  end

  // Bitmap write and registered read
  always_ff @(posedge clk) begin
    if (seen_we) seen_mem[seen_waddr] <= seen_wdata;
    seen_rd <= seen_mem[AW'(power)];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(prt_pkg::OUT_TDATA_W - DW - 1){1'b0}}, count, prim};
    end
  end

  // Checks
  `PRT_ASSERT(a_power_reduced, in_check |-> (power < m_reg), "power not below modulus")
  `PRT_ASSERT(a_count_in_limit, in_check |-> (count < limit), "step count past limit")
  `PRT_ASSERT(a_accept_path, accept |=> entry_state, "bad state after transfer")

endmodule

### sv/prt_modmul.sv
// ---------------------------------------------------------------------------
// prt_modmul
// Iterative modular multiplier: a * b mod m, one bit of b per cycle,
// MSB first, with double-and-add and a compare-subtract after the double and after the add.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module prt_modmul (
  input  logic              clk,
  input  logic              rst,
  input  prt_pkg::mul_req_t req,
  output prt_pkg::mul_rsp_t rsp
);

  localparam int DW = prt_pkg::DATA_W;
  localparam int IW = prt_pkg::BIT_IDX_W;

  logic [DW-1:0] acc;
  logic [DW-1:0] acc_next;
  logic [IW-1:0] idx;
  logic          busy;
  logic          done;

  logic [DW:0] dbl;
  logic [DW:0] dbl_red;
  logic [DW:0] sum;
  logic [DW:0] sum_red;
  logic [DW:0] mod_ext;

  // One double-and-add step, each half reduced by a single subtract
  always_comb begin
    mod_ext = {1'b0, req.m};
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    sum     = dbl_red + (req.b[idx] ? {1'b0, req.a} : '0);
    sum_red = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    acc_next = sum_red[DW-1:0];
  end

  // Bit counter and control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        idx  <= IW'(DW - 1);
      end else if (busy) begin
        idx <= idx - 1'b1;
        if (idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign rsp = '{busy: busy, done: done, result: acc};

  // Checks
  `PRT_ASSERT(a_acc_reduced, busy |-> (acc < req.m), "accumulator not reduced below modulus")
  `PRT_NEVER(a_start_busy, req.start && busy, "multiply started while busy")
  `PRT_ASSERT(a_last_bit_done, (busy && idx == '0) |=> (done && !busy), "multiply not done")

endmodule

### verif/primitive_root_tester_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// primitive_root_tester_unit_test
// Self-checking bench for the primitive root tester. Bases stream in, the
// bench predicts each result (primitive flag and count of powers passed) for
// the current modulus and checks every result transfer in order. It covers
// special moduli, a long receiver hold-off and random bases under several
// idling phases.
// ---------------------------------------------------------------------------
module primitive_root_tester_unit_test;

  localparam int                DATA_W        = prt_pkg::DATA_W;
  localparam int                MAX_MODULUS   = prt_pkg::MAX_MODULUS;
  localparam int                IN_TDATA_W    = prt_pkg::IN_TDATA_W;
  localparam int                OUT_TDATA_W   = prt_pkg::OUT_TDATA_W;
  localparam logic [DATA_W-1:0] MODULUS_RESET = prt_pkg::MODULUS_RESET;

  // Expected outcome of one base test
  typedef struct packed {
    logic              is_primitive;
    logic [DATA_W-1:0] steps_passed;
  } order_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // [9:0] base
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] is_primitive, [10:1] steps_passed
  logic                   cfg_wr_en;
  logic [DATA_W-1:0]      cfg_wr_data;

  order_result_t     pending_orders[$];
  logic [DATA_W-1:0] modulus_copy;
  int                mismatch_count = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                hold_left      = 0;

  primitive_root_tester_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Walk base^i mod m, stop on residue 1 or on a repeated residue
  function automatic order_result_t predict_order(input logic [DATA_W-1:0] base,
                                                  input logic [DATA_W-1:0] m);
    bit            seen [MAX_MODULUS];
    int unsigned   span;
    int unsigned   cur;
    int unsigned   count;
    order_result_t r;
    count = 0;
    if (m < 2) begin
      r.is_primitive = 1'b1;
    end else begin
      span = m - 2;
      cur  = 1 % m;
      for (int unsigned i = 1; i <= span; i++) begin
        cur = (cur * base) % m;
        if (cur == 1) break;
        if (cur < MAX_MODULUS) begin
          if (seen[cur]) break;
          seen[cur] = 1'b1;
        end
        count++;
      end
      r.is_primitive = (count >= span);
    end
    r.steps_passed = count[DATA_W-1:0];
    return r;
  endfunction

  // Send one base; valid stays high afterwards until the next call or a drain
  task automatic send_base(input logic [DATA_W-1:0] base);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(base);
    do @(posedge clk); while (!s_tready);
    pending_orders.push_back(predict_order(base, modulus_copy));
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_orders.size() != 0) @(negedge clk);
  endtask

  // Modulus write, only with the block idle
  task automatic set_modulus(input logic [DATA_W-1:0] m);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    modulus_copy  = m;
  endtask

  // Receiver: long hold-off when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    order_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_orders.size() == 0) begin
        $display("%0t: unexpected result is_primitive=%0d steps_passed=%0d",
                 $time, m_tdata[0], m_tdata[10:1]);
        mismatch_count++;
      end else begin
        want = pending_orders.pop_front();
        if (m_tdata[0] !== want.is_primitive) begin
          $display("%0t: is_primitive expected %0d actual %0d",
                   $time, want.is_primitive, m_tdata[0]);
          mismatch_count++;
        end
        if (m_tdata[10:1] !== want.steps_passed) begin
          $display("%0t: steps_passed expected %0d actual %0d",
                   $time, want.steps_passed, m_tdata[10:1]);
          mismatch_count++;
        end
      end
    end
  end

  // Reset value of the modulus, no write yet
  task automatic test_reset_modulus();
    send_base('0);
    send_base('1);
    send_base(DATA_W'(1));
  endtask

  // Moduli 0 and 1 (no division), 2 (empty loop), 3 and 4
  task automatic test_special_moduli();
    set_modulus(DATA_W'(0));
    send_base(DATA_W'(5));
    send_base('1);
    set_modulus(DATA_W'(1));
    send_base(DATA_W'(3));
    set_modulus(DATA_W'(2));
    send_base(DATA_W'(7));
    set_modulus(DATA_W'(3));
    send_base(DATA_W'(2));
    send_base(DATA_W'(1));
    set_modulus(DATA_W'(4));
    send_base(DATA_W'(3));
  endtask

  // Prime 7: primitive root, short order, zero, multiple, one, minus one
  task automatic test_small_prime();
    set_modulus(DATA_W'(7));
    send_base(DATA_W'(3));
    send_base(DATA_W'(2));
    send_base(DATA_W'(0));
    send_base(DATA_W'(7));
    send_base(DATA_W'(1));
    send_base(DATA_W'(6));
  endtask

  // Composite moduli: residue repeats without reaching 1, short order
  task automatic test_composite();
    set_modulus(DATA_W'(8));
    send_base(DATA_W'(2));
    send_base(DATA_W'(3));
    set_modulus(DATA_W'(9));
    send_base(DATA_W'(2));
  endtask

  // Largest modulus and a large prime
  task automatic test_largest_modulus();
    set_modulus('1);
    send_base(DATA_W'(2));
    send_base('1);
    send_base(DATA_W'(1022));
    set_modulus(DATA_W'(1021));
    send_base(DATA_W'(10));
    send_base(DATA_W'(2));
  endtask

  // Receiver holds off while bases keep coming: block fills and stalls input
  task automatic test_backpressure();
    set_modulus(DATA_W'(11));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 3000;
    for (int k = 0; k < 6; k++) send_base(DATA_W'($urandom_range(1023)));
    drain();
  endtask

  // Random bases in groups per modulus, one phase per idling mix
  task automatic test_random_phases();
    int unsigned primes [17] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41,
                                 43, 47, 53, 59, 61};
    int unsigned big_moduli [5] = '{1021, 1019, 1023, 1013, 1009};
    int          idle_mix [4][2] = '{'{0, 0}, '{49, 0}, '{0, 49}, '{24, 24}};
    int          group;
    logic [DATA_W-1:0] m;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_mix[ph][0];
      recv_stall_pct = idle_mix[ph][1];
      // one short group at a large modulus per phase
      set_modulus(DATA_W'(big_moduli[$urandom_range(4)]));
      for (int k = 0; k < 2; k++) send_base(DATA_W'($urandom_range(1023)));
      group = 0;
      while (group < 17) begin
        if ($urandom_range(99) < 60) m = DATA_W'(primes[$urandom_range(16)]);
        else m = DATA_W'($urandom_range(80, 2));
        set_modulus(m);
        for (int k = 0; k < 6; k++) begin
          if ($urandom_range(99) < 70) send_base(DATA_W'($urandom_range(1023)));
          else send_base(DATA_W'($urandom_range(m - 1)));
        end
        group += 6;
      end
    end
    drain();
  endtask

  // Run-time limit
  initial begin
    #60_000_000;
    $display("primitive_root_tester_unit verification failed");
    $finish;
  end

  // Test sequence
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    modulus_copy = MODULUS_RESET;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_modulus();
    test_special_moduli();
    test_small_prime();
    test_composite();
    test_largest_modulus();
    test_backpressure();
    test_random_phases();

    drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("primitive_root_tester_unit verification clean");
    end else begin
      $display("primitive_root_tester_unit verification failed");
    end
    $finish;
  end

endmodule
